FILE: rtl/adbr_pkg.sv
// Shared types and constants for the ADC button debouncer with auto-repeat.
`timescale 1ns / 1ps
`default_nettype none

package adbr_pkg;

  // Tick period and converter resolution of the button line.
  localparam int USEC_PER_TICK = 100;
  localparam int ADC_BITS      = 10;

  localparam int SAMPLE_W  = 10;
  localparam int ACC_W     = 18;
  localparam int ELAPSED_W = 17;
  localparam int DELAY_W   = 16;
  localparam int SHIFT_W   = 4;
  localparam int PHASE_W   = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [SAMPLE_W-1:0] LEVEL_MAX =
    (ADC_BITS >= 10) ? SAMPLE_W'(1023) : SAMPLE_W'((1 << ADC_BITS) - 1);
  localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};
  localparam logic [ACC_W-1:0] ACC_RESET = ACC_W'(1023 << 3);

  // Button phase codes.
  localparam logic [PHASE_W-1:0] PH_UP       = 2'd0;
  localparam logic [PHASE_W-1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_PRESSED  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_PRESS_THR   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RELEASE_THR = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_DLY  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE_DLY = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_FILTER_SHIFT = 3'd4;

  typedef struct packed {
    logic [SAMPLE_W-1:0] press_thr;
    logic [SAMPLE_W-1:0] release_thr;
    logic [DELAY_W-1:0]  repeat_dly;
    logic [DELAY_W-1:0]  debounce_dly;
    logic [SHIFT_W-1:0]  filter_shift;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic                key_event;
    logic [SAMPLE_W-1:0] key_level;
    logic [PHASE_W-1:0]  phase;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/adbr_cfg.sv
// Configuration register file of the button debouncer.
`timescale 1ns / 1ps
`default_nettype none

module adbr_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [adbr_pkg::CFG_ADDR_W-1:0] wr_addr_i,
  input  logic [adbr_pkg::CFG_DATA_W-1:0] wr_data_i,
  output adbr_pkg::cfg_t                 cfg_o
);
  import adbr_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_addr_i)
        CFG_PRESS_THR:    cfg_d.press_thr    = wr_data_i[SAMPLE_W-1:0];
        CFG_RELEASE_THR:  cfg_d.release_thr  = wr_data_i[SAMPLE_W-1:0];
        CFG_REPEAT_DLY:   cfg_d.repeat_dly   = wr_data_i[DELAY_W-1:0];
        CFG_DEBOUNCE_DLY: cfg_d.debounce_dly = wr_data_i[DELAY_W-1:0];
        CFG_FILTER_SHIFT: cfg_d.filter_shift = wr_data_i[SHIFT_W-1:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_thr    <= SAMPLE_W'(944);
      cfg_q.release_thr  <= SAMPLE_W'(984);
      cfg_q.repeat_dly   <= '0;
      cfg_q.debounce_dly <= DELAY_W'(5000);
      cfg_q.filter_shift <= SHIFT_W'(3);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/adbr_filter.sv
// Leaky integrator low-pass filter of the button line.
`timescale 1ns / 1ps
`default_nettype none

module adbr_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [adbr_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [adbr_pkg::SHIFT_W-1:0]  shift_i,
  output logic [adbr_pkg::SAMPLE_W-1:0] level_o
);
  import adbr_pkg::*;

  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [SHIFT_W-1:0] k;
  logic [ACC_W:0]     sum;
  logic [ACC_W-1:0]   level_full;

  // Clamp the shift into its usable range.
  always_comb begin
    if (shift_i == '0) begin
      k = SHIFT_W'(1);
    end else if (shift_i > SHIFT_W'(8)) begin
      k = SHIFT_W'(8);
    end else begin
      k = shift_i;
    end
  end

  always_comb begin
    sum = {1'b0, acc_q} - {1'b0, (acc_q >> k)} + (ACC_W+1)'(sample_i);
    acc_d = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    level_full = acc_d >> k;
    level_o = (level_full > ACC_W'(LEVEL_MAX)) ? LEVEL_MAX : level_full[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= ACC_RESET;
    end else if (step_i) begin
      acc_q <= acc_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/adbr_fsm.sv
// Up / debounce / pressed phase machine with debounce and repeat timing.
`timescale 1ns / 1ps
`default_nettype none

module adbr_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [adbr_pkg::SAMPLE_W-1:0] level_i,
  input  adbr_pkg::cfg_t                cfg_i,
  output adbr_pkg::result_t             result_o
);
  import adbr_pkg::*;

  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [SAMPLE_W-1:0]  held_q, held_d;
  logic                 key_event;

  logic [ELAPSED_W-1:0] limit;
  logic [ELAPSED_W-1:0] advanced;
  logic [ELAPSED_W-1:0] elapsed_next;
  logic                 reached;

  // One timer shared by the debounce and repeat waits.
  always_comb begin
    limit = (phase_q == PH_PRESSED) ? ELAPSED_W'(cfg_i.repeat_dly)
                                    : ELAPSED_W'(cfg_i.debounce_dly);
    reached = (elapsed_q >= limit);
    advanced = elapsed_q + ELAPSED_W'(USEC_PER_TICK);
    elapsed_next = (advanced > limit) ? limit : advanced;
  end

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    held_d    = held_q;
    key_event = 1'b0;
    unique case (phase_q)
      PH_DEBOUNCE: begin
        if (reached) begin
          held_d    = level_i;
          key_event = 1'b1;
          elapsed_d = '0;
          phase_d   = PH_PRESSED;
        end else begin
          elapsed_d = elapsed_next;
        end
      end
      PH_PRESSED: begin
        if (level_i >= cfg_i.release_thr) begin
          phase_d = PH_UP;
        end else if (cfg_i.repeat_dly != '0) begin
          if (reached) begin
            key_event = 1'b1;
            elapsed_d = '0;
          end else begin
            elapsed_d = elapsed_next;
          end
        end
      end
      default: begin
        // Up, and the unused code that falls back to up.
        phase_d = PH_UP;
        if (level_i <= cfg_i.press_thr) begin
          elapsed_d = '0;
          phase_d   = PH_DEBOUNCE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_UP;
      elapsed_q <= '0;
      held_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      held_q    <= held_d;
    end
  end

  always_comb begin
    result_o.level     = level_i;
    result_o.key_event = key_event;
    result_o.key_level = held_d;
    result_o.phase     = phase_d;
  end

endmodule

`default_nettype wire

FILE: rtl/adc_button_debounce_repeat_top.sv
// Top level of the ADC button debouncer with auto-repeat.
`timescale 1ns / 1ps
`default_nettype none

// Each transfer on the slave stream is one timer tick carrying a 10-bit ADC
// reading of a resistor-ladder button line; each tick produces exactly one
// transfer on the master stream. A leaky integrator (acc - acc>>k + sample,
// with k from the filter shift register clamped to 1..8) smooths the line and
// the filtered level is acc>>k. The phase machine starts debouncing when the
// level falls to the press threshold, latches the level and flags a key event
// once the debounce delay has elapsed, and while pressed either returns to up
// at the release threshold or re-flags the held level every repeat delay
// (zero disables repeat). Time advances a fixed 100 us per tick. The input
// register captures the sample at its transfer, and a step moves it through
// the filter and phase logic into the output register once that register is
// free. Throughput is one tick per cycle while the master stream is not
// stalled, as the integrator and phase registers update on each step.
// While a result waits in the output register the input register takes one
// more tick and then holds s_axis_tready low until that result transfers.
// Write configuration only while no tick is in flight; writes to indexes
// beyond the filter shift are dropped.
module adc_button_debounce_repeat_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i,
  // Sample stream in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] adc_sample, [15:10] zero
  // Result stream out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [9:0] filtered_level, [19:10] key_level,
                                      // [21:20] button_phase, [23:22] zero
  output logic [0:0]  m_axis_tuser    // [0] key_event
);
  import adbr_pkg::*;

  cfg_t    cfg;
  result_t result;

  logic                in_valid_q, in_valid_d;
  logic [SAMPLE_W-1:0] sample_q;
  logic                out_valid_q, out_valid_d;
  result_t             out_q;
  logic [SAMPLE_W-1:0] level;
  logic                s_accept;
  logic                out_free;
  logic                step;

  // The config port never stalls.
  assign cfg_ready_o = 1'b1;

  adbr_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_addr_i (cfg_addr_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // Advance the tick held in the input register whenever the output register
  // is empty or its result leaves in this cycle.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || step;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold the sample until it steps, hold the result
  // until its transfer.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      sample_q <= s_axis_tdata[SAMPLE_W-1:0];
    end
    if (step) begin
      out_q <= result;
    end
  end

  adbr_filter u_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (sample_q),
    .shift_i  (cfg.filter_shift),
    .level_o  (level)
  );

  adbr_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .level_i  (level),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.phase, out_q.key_level, out_q.level};
  assign m_axis_tuser  = out_q.key_event;

endmodule

`default_nettype wire

FILE: rtl/adbr_checker.sv
// Port-level assertions for the button debouncer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module adbr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser
);
  import adbr_pkg::*;

  // A stalled result holds valid and payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A key event is only reported in the pressed phase.
  a_event_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[21:20] == PH_PRESSED)
    else $error("key event outside pressed phase");

  // Only the three defined phase codes appear on the output.
  a_phase_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[21:20] == PH_UP ||
                       m_axis_tdata[21:20] == PH_DEBOUNCE ||
                       m_axis_tdata[21:20] == PH_PRESSED))
    else $error("unused phase code on output");

  // An empty pipeline always takes a sample.
  a_accept_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && $past(!s_axis_tvalid) && $past(rst_ni) |-> s_axis_tready)
    else $error("idle block refused a sample");

endmodule

bind adc_button_debounce_repeat_top adbr_checker u_adbr_checker (.*);

`default_nettype wire
